FILE: rtl/core/permuted_bucket_vote_counter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the permuted bucket vote counter
// Shared concurrent-assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef PERMUTED_BUCKET_VOTE_COUNTER_ASSERT_SVH
`define PERMUTED_BUCKET_VOTE_COUNTER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PBVC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PBVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pbvc_pkg.sv
// ----------------------------------------------------------------------------
// pbvc_pkg
// Types and constants of the permuted bucket vote counter.
// ----------------------------------------------------------------------------
`default_nettype none

package pbvc_pkg;

  localparam int MAX_LENGTH       = 4096;
  localparam int MAX_BUCKET_WIDTH = 32;
  localparam int SCORE_BITS       = 8;

  localparam int LOC_BITS   = $clog2(MAX_LENGTH);
  localparam int LEN_BITS   = LOC_BITS + 1;
  localparam int BW_BITS    = $clog2(MAX_BUCKET_WIDTH) + 1;
  localparam int HALF_SHIFT = $clog2(MAX_BUCKET_WIDTH) - 1;
  localparam int HIT_BITS   = 13;
  localparam int ORD_BITS   = 12;
  localparam int BIDX_BITS  = 12;
  localparam int MULT_BITS  = 12;

  // bucket_index * w + n * (MAX_BUCKET_WIDTH / 2)
  localparam int PROD_BITS  = LEN_BITS + BW_BITS - 1;
  localparam int STEP_BITS  = $clog2(PROD_BITS);

  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = LEN_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIGNAL_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BUCKET_WIDTH   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VOTE_THRESHOLD = 2'd2;

  localparam logic CMD_VOTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [BIDX_BITS-1:0] bucket_index;
    logic [MULT_BITS-1:0] multiplier;
  } req_t;

  typedef struct packed {
    logic [LOC_BITS-1:0] hit_location;
    logic [ORD_BITS-1:0] hit_ordinal;
    logic                hit_valid;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/permuted_bucket_vote_counter.sv
// ----------------------------------------------------------------------------
// permuted_bucket_vote_counter
// Location voting of a sparse FFT: scores the w locations of a permuted
// bucket in a score RAM and reports each location reaching the threshold.
//
//   channel   direction  handshake            payload
//   request   in         start & !busy        request (req_t)
//   result    out        strobe, one cycle    result (res_t)
//   config    in         cfg_we               cfg_index, cfg_data
//
// A vote holds busy through three passes of the shared serial modular
// multiplier (range start, multiplier mod n, start location), a walk over
// the w locations with one score read-modify-write per cycle through the
// RAM, and an end state; the last result strobes in the cycle after. A
// clear holds busy while it zeroes the RAM, one entry per cycle; the same
// sweep runs after reset. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "permuted_bucket_vote_counter_assert.svh"

module permuted_bucket_vote_counter import pbvc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  req_t                      request,
  output logic                      strobe,
  output res_t                      result,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LOW   = 7'b0000100,
    S_AMOD  = 7'b0001000,
    S_LOC   = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_END   = 7'b1000000
  } state_t;

  state_t state;

  logic [LEN_BITS-1:0]   signal_length;
  logic [BW_BITS-1:0]    bucket_width;
  logic [SCORE_BITS-1:0] vote_threshold;

  logic [LOC_BITS-1:0]   clr_addr;
  logic [HIT_BITS-1:0]   hit_count;
  logic [BW_BITS-1:0]    rem;
  logic                  rd_pend;
  logic                  fwd;
  logic [SCORE_BITS-1:0] fwd_data;
  logic [LOC_BITS-1:0]   rd_addr_q;
  logic                  pend_valid;
  logic [LOC_BITS-1:0]   pend_loc;
  logic [ORD_BITS-1:0]   pend_ord;
  logic [MULT_BITS-1:0]  mult_q;
  logic [LOC_BITS-1:0]   low_q;
  logic [LOC_BITS-1:0]   a_q;
  logic [LOC_BITS-1:0]   loc;

  logic [LEN_BITS-1:0]   n_cfg;
  logic [BW_BITS-1:0]    w_cfg;
  logic [BW_BITS-1:0]    half;
  logic [PROD_BITS-1:0]  y_low;
  logic [LOC_BITS-1:0]   one_n;
  logic [LEN_BITS-1:0]   loc_sum;
  logic [LEN_BITS-1:0]   loc_next;

  logic                  rd_issue;
  logic [SCORE_BITS-1:0] s_in;
  logic [SCORE_BITS-1:0] s_inc;
  logic                  can_inc;
  logic                  hit;

  logic                  ram_we;
  logic [LOC_BITS-1:0]   ram_waddr;
  logic [SCORE_BITS-1:0] ram_wdata;
  logic [SCORE_BITS-1:0] ram_rdata;

  logic                  mm_start;
  logic [LOC_BITS-1:0]   mm_x;
  logic [PROD_BITS-1:0]  mm_y;
  logic                  mm_done;
  logic [LOC_BITS-1:0]   mm_result;

  assign busy = (state != S_IDLE);

  always_comb begin
    n_cfg = ((signal_length == '0) || (signal_length > LEN_BITS'(MAX_LENGTH)))
            ? LEN_BITS'(MAX_LENGTH) : signal_length;
    w_cfg = (bucket_width > BW_BITS'(MAX_BUCKET_WIDTH))
            ? BW_BITS'(MAX_BUCKET_WIDTH) : bucket_width;
    half  = w_cfg >> 1;
    // J*w - w/2, lifted by a multiple of n so it stays positive
    y_low = PROD_BITS'(request.bucket_index) * PROD_BITS'(w_cfg)
          + (PROD_BITS'(n_cfg) << HALF_SHIFT) - PROD_BITS'(half);
    one_n = {{(LOC_BITS-1){1'b0}}, (n_cfg != LEN_BITS'(1))};
    loc_sum  = {1'b0, loc} + {1'b0, a_q};
    loc_next = (loc_sum >= n_cfg) ? loc_sum - n_cfg : loc_sum;
  end

  always_comb begin
    rd_issue  = (state == S_WALK) && (rem != '0);
    s_in      = fwd ? fwd_data : ram_rdata;
    s_inc     = s_in + 1'b1;
    can_inc   = rd_pend && (s_in != SCORE_MAX);
    hit       = can_inc && (s_inc == vote_threshold);
    ram_we    = (state == S_CLEAR) || can_inc;
    ram_waddr = (state == S_CLEAR) ? clr_addr : rd_addr_q;
    ram_wdata = (state == S_CLEAR) ? '0 : s_inc;
  end

  always_comb begin
    mm_start = 1'b0;
    mm_x     = one_n;
    mm_y     = y_low;
    case (state)
      S_IDLE: begin
        mm_start = start && (request.command == CMD_VOTE);
      end
      S_LOW: begin
        mm_start = mm_done;
        mm_y     = PROD_BITS'(mult_q);
      end
      S_AMOD: begin
        mm_start = mm_done;
        mm_x     = low_q;
        mm_y     = PROD_BITS'(mm_result);
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  pbvc_mod_mul u_mod_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .modulus (n_cfg),
    .x       (mm_x),
    .y       (mm_y),
    .done    (mm_done),
    .result  (mm_result)
  );

  pbvc_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (MAX_LENGTH)
  ) u_scores (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (loc),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      hit_count      <= '0;
      rem            <= '0;
      rd_pend        <= 1'b0;
      fwd            <= 1'b0;
      pend_valid     <= 1'b0;
      strobe         <= 1'b0;
      signal_length  <= LEN_BITS'(4096);
      bucket_width   <= BW_BITS'(16);
      vote_threshold <= SCORE_BITS'(1);
    end else begin
      strobe  <= 1'b0;
      rd_pend <= rd_issue;
      // read and write of one entry in the same cycle: take the new score
      fwd     <= rd_issue && ram_we && (loc == ram_waddr);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SIGNAL_LENGTH:  signal_length  <= cfg_data[LEN_BITS-1:0];
          CFG_BUCKET_WIDTH:   bucket_width   <= cfg_data[BW_BITS-1:0];
          CFG_VOTE_THRESHOLD: vote_threshold <= cfg_data[SCORE_BITS-1:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (request.command == CMD_CLEAR) begin
              state     <= S_CLEAR;
              clr_addr  <= '0;
              hit_count <= '0;
            end else begin
              state <= S_LOW;
            end
          end
        end
        S_LOW: begin
          if (mm_done) begin
            state <= S_AMOD;
          end
        end
        S_AMOD: begin
          if (mm_done) begin
            state <= S_LOC;
          end
        end
        S_LOC: begin
          if (mm_done) begin
            rem   <= w_cfg;
            state <= (w_cfg == '0) ? S_END : S_WALK;
          end
        end
        S_WALK: begin
          if (rd_issue) begin
            rem <= rem - 1'b1;
          end
          if (hit) begin
            hit_count  <= hit_count + 1'b1;
            pend_valid <= 1'b1;
            if (pend_valid) begin
              strobe <= 1'b1;
            end
          end
          if ((rem == '0) && !rd_pend) begin
            state <= S_END;
          end
        end
        S_END: begin
          strobe     <= 1'b1;
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    fwd_data  <= ram_wdata;
    rd_addr_q <= loc;
    case (state)
      S_IDLE: begin
        mult_q <= request.multiplier;
      end
      S_LOW: begin
        if (mm_done) begin
          low_q <= mm_result;
        end
      end
      S_AMOD: begin
        if (mm_done) begin
          a_q <= mm_result;
        end
      end
      S_LOC: begin
        if (mm_done) begin
          loc <= mm_result;
        end
      end
      S_WALK: begin
        if (rd_issue) begin
          loc <= loc_next[LOC_BITS-1:0];
        end
        if (hit) begin
          pend_loc <= rd_addr_q;
          pend_ord <= hit_count[ORD_BITS-1:0];
          if (pend_valid) begin
            result <= '{hit_location: pend_loc, hit_ordinal: pend_ord,
                        hit_valid: 1'b1, last: 1'b0};
          end
        end
      end
      S_END: begin
        if (pend_valid) begin
          result <= '{hit_location: pend_loc, hit_ordinal: pend_ord,
                      hit_valid: 1'b1, last: 1'b1};
        end else begin
          result <= '{hit_location: '0, hit_ordinal: '0,
                      hit_valid: 1'b0, last: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  `PBVC_ASSERT_SAME(a_clear_writes_zero, state == S_CLEAR, ram_we && ram_wdata == '0, "bad clear")
  `PBVC_ASSERT_SAME(a_empty_is_last, strobe && !result.hit_valid, result.last, "empty not last")
  `PBVC_ASSERT_SAME(a_walk_in_range, rd_issue, ({1'b0, loc} < n_cfg), "walk past length")
  `PBVC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

endmodule

`default_nettype wire

FILE: rtl/core/pbvc_ram.sv
// ----------------------------------------------------------------------------
// pbvc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pbvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/pbvc_mod_mul.sv
// ----------------------------------------------------------------------------
// pbvc_mod_mul
// Bit-serial modular multiply: result = (x * y) mod modulus, x below modulus.
// One bit of y per cycle, MSB first; done pulses with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pbvc_mod_mul import pbvc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [LEN_BITS-1:0]  modulus,
  input  logic [LOC_BITS-1:0]  x,
  input  logic [PROD_BITS-1:0] y,
  output logic                 done,
  output logic [LOC_BITS-1:0]  result
);

  logic                 active;
  logic [STEP_BITS-1:0] cnt;
  logic [PROD_BITS-1:0] ysh;
  logic [LOC_BITS-1:0]  x_q;
  logic [LOC_BITS-1:0]  acc;

  logic [LEN_BITS-1:0]  dbl;
  logic [LEN_BITS-1:0]  dbl_r;
  logic [LEN_BITS-1:0]  sum;
  logic [LEN_BITS-1:0]  acc_next;

  always_comb begin
    dbl      = {acc, 1'b0};
    dbl_r    = (dbl >= modulus) ? dbl - modulus : dbl;
    sum      = dbl_r + (ysh[PROD_BITS-1] ? {1'b0, x_q} : '0);
    acc_next = (sum >= modulus) ? sum - modulus : sum;
  end

  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= STEP_BITS'(PROD_BITS - 1);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ysh <= y;
      x_q <= x;
    end else if (active) begin
      acc <= acc_next[LOC_BITS-1:0];
      ysh <= {ysh[PROD_BITS-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire
